>>> hdl/tslb_pkg.sv
// ---------------------------------------------------------------------------
// tslb_pkg
// Sizes and transaction types of the texture slot LRU binder.
// ---------------------------------------------------------------------------
package tslb_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int ID_WIDTH    = 16;
    localparam int STAMP_WIDTH = 32;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);

    typedef struct packed {
        logic [15:0] owner_id;
        logic        auto_pick;
        logic [3:0]  want_slot;
    } t_bind_req;

    typedef struct packed {
        logic [3:0]  granted_slot;
        logic        was_hit;
        logic        evicted_valid;
        logic [15:0] evicted_id;
        logic [31:0] use_count;
    } t_bind_rsp;

    // one slot entry as kept in the slot memory
    typedef struct packed {
        logic [ID_WIDTH-1:0]    owner;
        logic [STAMP_WIDTH-1:0] stamp;
        logic [31:0]            uses;
    } t_slot_entry;

endpackage

>>> hdl/texture_slot_lru_binder.sv
// ---------------------------------------------------------------------------
// texture_slot_lru_binder
// Least-recently-bound replacement over a set of binding slots. Slot entries
// sit in a single-port-read synchronous memory; a sequencer scans it once
// per request, then reads, updates and writes back the chosen slot.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ------------------------
//  request   in         i_in_valid / o_in_stall   i_in_data  (t_bind_req)
//  response  out        o_out_valid / i_out_stall o_out_data (t_bind_rsp)
//
//  A request is accepted, then the scan does one memory read per slot, the
//  last read drains, the chosen slot is read, and finally it is written back
//  and the response is loaded. The scan goes through the one memory read port.
//  A new request is taken as soon as the previous one is written back, even
//  while its response still waits in the output register; a stalled response
//  holds the write-back of the next request until it is taken.
//  Reset empties every slot through the valid flops and zeroes the stamp
//  counter; the memory itself needs no clearing pass.
// ---------------------------------------------------------------------------
module texture_slot_lru_binder
    import tslb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_bind_req i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_bind_rsp o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_WRITE
    } t_state;

    // slot memory; valid marks live in flops so reset empties all slots at once
    t_slot_entry mem [SLOT_COUNT];
    t_slot_entry r_rd_data;

    t_state                 r_state;
    logic [SLOT_COUNT-1:0]  r_valid;
    logic [STAMP_WIDTH-1:0] r_counter;

    // captured request
    logic [ID_WIDTH-1:0]    r_id;
    logic                   r_auto;
    logic [3:0]             r_want;

    // scan bookkeeping
    logic [SLOT_W-1:0]      r_idx;
    logic                   r_pend;
    logic [SLOT_W-1:0]      r_pend_idx;
    logic                   r_hit;
    logic [SLOT_W-1:0]      r_hit_idx;
    logic                   r_empty;
    logic [SLOT_W-1:0]      r_empty_idx;
    logic [SLOT_W-1:0]      r_best_idx;
    logic [STAMP_WIDTH-1:0] r_best_stamp;
    logic [SLOT_W-1:0]      r_slot;

    logic                   r_out_valid;
    t_bind_rsp              r_out;

    // next values of the scan trackers
    logic                   n_hit;
    logic [SLOT_W-1:0]      n_hit_idx;
    logic                   n_empty;
    logic [SLOT_W-1:0]      n_empty_idx;
    logic [SLOT_W-1:0]      n_best_idx;
    logic [STAMP_WIDTH-1:0] n_best_stamp;
    logic [SLOT_W-1:0]      n_slot;

    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   commit;
    logic                   ev;
    t_slot_entry            wr_data;
    t_bind_rsp              n_out;
    logic                   pend_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // fold one slot read into the hit / first-empty / oldest trackers
    always_comb begin
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_empty      = r_empty;
        n_empty_idx  = r_empty_idx;
        n_best_idx   = r_best_idx;
        n_best_stamp = r_best_stamp;
        pend_valid   = r_valid[r_pend_idx];
        if (r_pend) begin
            if (!r_hit && pend_valid && (r_rd_data.owner == r_id)) begin
                n_hit     = 1'b1;
                n_hit_idx = r_pend_idx;
            end
            if (!r_empty && !pend_valid) begin
                n_empty     = 1'b1;
                n_empty_idx = r_pend_idx;
            end
            // strictly smaller only, so the first slot wins a tie
            if (pend_valid && (r_rd_data.stamp < r_best_stamp)) begin
                n_best_idx   = r_pend_idx;
                n_best_stamp = r_rd_data.stamp;
            end
        end
    end

    // slot choice: hit first, then auto pick, then the requested slot saturated
    always_comb begin
        priority if (r_hit) begin
            n_slot = r_hit_idx;
        end else if (r_auto) begin
            n_slot = r_empty ? r_empty_idx : r_best_idx;
        end else if (32'(r_want) >= 32'(SLOT_COUNT)) begin
            n_slot = SLOT_W'(SLOT_COUNT - 1);
        end else begin
            n_slot = SLOT_W'(r_want);
        end
    end

    // memory read port: scan address, then the chosen slot
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        unique case (r_state)
            S_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
            end
            S_PICK: begin
                rd_en   = 1'b1;
                rd_addr = n_slot;
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_idx;
            end
        endcase
    end

    // write-back entry and response; fires once the output register is free
    always_comb begin
        commit = (r_state == S_WRITE) && (!r_out_valid || !i_out_stall);
        ev     = !r_hit && r_valid[r_slot];
        wr_data.owner = r_hit ? r_rd_data.owner : r_id;
        wr_data.stamp = r_counter;
        wr_data.uses  = r_hit ? (r_rd_data.uses + 32'd1) : 32'd1;
        n_out.granted_slot  = 4'(r_slot);
        n_out.was_hit       = r_hit;
        n_out.evicted_valid = ev;
        n_out.evicted_id    = ev ? 16'(r_rd_data.owner) : 16'd0;
        n_out.use_count     = wr_data.uses;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (commit) begin
            mem[r_slot] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            // drop the response once the consumer takes it, unless a new one loads
            if (r_out_valid && !i_out_stall && !commit) begin
                r_out_valid <= 1'b0;
            end
            r_pend     <= (r_state == S_SCAN);
            r_pend_idx <= r_idx;
            if (r_pend) begin
                r_hit        <= n_hit;
                r_hit_idx    <= n_hit_idx;
                r_empty      <= n_empty;
                r_empty_idx  <= n_empty_idx;
                r_best_idx   <= n_best_idx;
                r_best_stamp <= n_best_stamp;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_id         <= ID_WIDTH'(i_in_data.owner_id);
                        r_auto       <= i_in_data.auto_pick;
                        r_want       <= i_in_data.want_slot;
                        r_idx        <= '0;
                        r_hit        <= 1'b0;
                        r_hit_idx    <= '0;
                        r_empty      <= 1'b0;
                        r_empty_idx  <= '0;
                        r_best_idx   <= '0;
                        r_best_stamp <= '1;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // advance through every slot, one read per cycle
                    r_idx <= r_idx + SLOT_W'(1);
                    if (r_idx == SLOT_W'(SLOT_COUNT - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    r_slot  <= n_slot;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    // hold until the previous response has left
                    if (commit) begin
                        r_valid[r_slot] <= 1'b1;
                        r_counter       <= r_counter + STAMP_WIDTH'(1);
                        r_out           <= n_out;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
